// File: design/idq_pkg.sv
// Package for the indexed double-ended queue: request and response beat types,
// function and status codes, and the shift command that the storage cells decode.
// No dependencies.
package idq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [3:0] FN_POP_FRONT  = 4'd2;
    localparam logic [3:0] FN_POP_BACK   = 4'd3;
    localparam logic [3:0] FN_INSERT     = 4'd4;
    localparam logic [3:0] FN_ERASE      = 4'd5;
    localparam logic [3:0] FN_READ       = 4'd6;
    localparam logic [3:0] FN_PEEK_FRONT = 4'd7;
    localparam logic [3:0] FN_PEEK_BACK  = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_OPEN,
        SH_CLOSE
    } shift_op_t;

    typedef struct packed {
        logic [3:0]  func;
        logic [4:0]  position;
        logic [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
        logic [4:0]  count;
        logic        is_empty;
    } rsp_t;

endpackage

// File: design/indexed_double_ended_queue_core.sv
// Top level of the indexed double-ended queue: request decode, the chain of
// storage cells and the response register. Uses idq_pkg and idq_cell.
//
//   channel | signals                     | beat content
//   --------+-----------------------------+---------------------------------
//   req     | req_valid, req_stall, req   | func, position, item_value
//   rsp     | rsp_valid, rsp_stall, rsp   | result_value, status, count, is_empty
//
// On a request, the cells at and beyond the position shift or load in the same
// cycle, so one request is accepted per clock while the response register drains.
// The response is registered and appears in the cycle after the request beat.
// Reset clears the fill count and the response valid; cell contents are not reset.
// A stalled response holds the request side stalled until it is taken.
module indexed_double_ended_queue_core #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = idq_pkg::DEF_DATA_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  idq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output idq_pkg::rsp_t rsp
);
    import idq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic                  req_beat;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      pos_w;
    logic [CMP_W-1:0]      cnt_w;
    logic [CNT_W-1:0]      last_cnt;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      pos_idx;
    shift_op_t             op;
    logic [IDX_W-1:0]      at;
    logic                  rd_en;
    logic [1:0]            status;
    logic [63:0]           din_wide;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           rd_wide;
    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    assign req_beat = req_valid && !req_stall;
    assign req_stall = rsp_valid_reg && rsp_stall;

    assign full     = (fill_reg == CNT_W'(CAPACITY));
    assign empty    = (fill_reg == '0);
    assign pos_w    = CMP_W'(req.position);
    assign cnt_w    = CMP_W'(fill_reg);
    assign last_cnt = fill_reg - 1'b1;
    assign last_idx = last_cnt[IDX_W-1:0];
    assign pos_idx  = pos_w[IDX_W-1:0];
    assign din_wide = {32'd0, req.item_value};
    assign din      = din_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        op     = SH_HOLD;
        at     = '0;
        rd_en  = 1'b0;
        status = ST_OK;
        case (req.func)
            FN_PUSH_FRONT:
            begin
                if (full)
                    status = ST_FULL;
                else
                    op = SH_OPEN;
            end
            FN_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op = SH_OPEN;
                    at = fill_reg[IDX_W-1:0];
                end
            end
            FN_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    op    = SH_CLOSE;
                    rd_en = 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (empty)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    op    = SH_CLOSE;
                    at    = last_idx;
                    rd_en = 1'b1;
                end
            end
            FN_INSERT:
            begin
                if (pos_w > cnt_w)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op = SH_OPEN;
                    at = pos_idx;
                end
            end
            FN_ERASE:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    op    = SH_CLOSE;
                    at    = pos_idx;
                    rd_en = 1'b1;
                end
            end
            FN_READ:
            begin
                if (pos_w >= cnt_w)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    at    = pos_idx;
                    rd_en = 1'b1;
                end
            end
            FN_PEEK_FRONT:
            begin
                if (empty)
                    status = ST_RANGE;
                else
                    rd_en = 1'b1;
            end
            FN_PEEK_BACK:
            begin
                if (empty)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    at    = last_idx;
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                status = ST_RANGE;
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (k == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_q[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_q[k+1];
            end
            idq_cell #(
                .CAPACITY   (CAPACITY),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (k),
                .IDX_W      (IDX_W),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk   (clk),
                .op    (req_beat ? op : SH_HOLD),
                .at    (at),
                .cnt   (fill_reg),
                .din   (din),
                .left  (left_d),
                .right (right_d),
                .q     (cell_q[k])
            );
        end
    endgenerate

    assign rd_data = rd_en ? cell_q[at] : '0;
    assign rd_wide = 64'(rd_data);

    always_comb
    begin
        fill_next = fill_reg;
        if (req_beat)
        begin
            case (op)
                SH_OPEN:  fill_next = fill_reg + 1'b1;
                SH_CLOSE: fill_next = fill_reg - 1'b1;
                default:  fill_next = fill_reg;
            endcase
        end
    end

    always_comb
    begin
        rsp_next.result_value = rd_wide[31:0];
        rsp_next.status       = status;
        rsp_next.count        = 5'(fill_next);
        rsp_next.is_empty     = (fill_next == '0);
        if (req_beat)
            rsp_valid_next = 1'b1;
        else
            rsp_valid_next = rsp_valid_reg && rsp_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: design/idq_cell.sv
// One storage cell of the queue chain. It holds one entry and, on a shift
// command, loads the new value or takes its left or right neighbor. Uses idq_pkg.
module idq_cell #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = idq_pkg::DEF_DATA_WIDTH,
    parameter int IDX        = 0,
    parameter int IDX_W      = $clog2(CAPACITY),
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                    clk,
    input  idq_pkg::shift_op_t      op,
    input  logic [IDX_W-1:0]        at,
    input  logic [CNT_W-1:0]        cnt,
    input  logic [DATA_WIDTH-1:0]   din,
    input  logic [DATA_WIDTH-1:0]   left,
    input  logic [DATA_WIDTH-1:0]   right,
    output logic [DATA_WIDTH-1:0]   q
);
    import idq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NXT_CNT = CNT_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            SH_OPEN:
            begin
                if (MY_IDX == at)
                begin
                    data_next = din;
                end
                else if (MY_IDX > at && MY_CNT <= cnt)
                begin
                    data_next = left;
                end
            end
            SH_CLOSE:
            begin
                if (MY_IDX >= at && NXT_CNT < cnt)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// File: design/idq_checker.sv
// Port-level checks for the indexed double-ended queue, bound to the top level.
// Uses idq_pkg.
module idq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input idq_pkg::rsp_t rsp
);
    import idq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request gave no response beat");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.result_value == 32'd0)
        else $error("error response carries a value");

endmodule

bind indexed_double_ended_queue_core idq_checker u_idq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
